// ===== rtl/core/pressure_sensor_compensation_macros.svh =====
// Shared assertion macros for the compensation core.
`ifndef PRESSURE_SENSOR_COMPENSATION_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PSC_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("psc check failed");

// Next-cycle implication, checked out of reset.
`define PSC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("psc check failed");

`endif

// ===== rtl/core/psc_pkg.sv =====
`default_nettype none
package psc_pkg;

  // Data path word width.
  localparam int unsigned DATA_W = 32;

  // Configuration register indexes.
  localparam logic [1:0] REG_OVERSAMPLING = 2'd0;
  localparam logic [1:0] REG_CAL_A        = 2'd1;
  localparam logic [1:0] REG_CAL_B        = 2'd2;
  localparam logic [1:0] REG_CAL_C        = 2'd3;

  // Compensation constants.
  localparam logic [31:0] B6_OFFSET   = 32'd4000;
  localparam logic [31:0] P_SQ_COEF   = 32'd3038;
  localparam logic [31:0] P_LIN_COEF  = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_OFFSET    = 32'd3791;
  localparam logic [31:0] B7_SCALE    = 32'd50000;
  localparam logic [31:0] B4_BIAS     = 32'd32768;

  // Control handed to a pipelined divider.
  typedef struct packed {
    logic valid;
    logic adv;
  } psc_div_ctl_t;

  // Arithmetic right shift of a 32-bit word.
  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    asr32 = $unsigned($signed(v) >>> s);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/psc_udiv.sv =====
`default_nettype none
`include "pressure_sensor_compensation_macros.svh"
module psc_udiv
  import psc_pkg::*;
#(
  parameter int unsigned W  = DATA_W,
  parameter int unsigned PW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire psc_div_ctl_t  ctl,
  input  wire logic [W-1:0]  num,
  input  wire logic [W-1:0]  den,
  input  wire logic [PW-1:0] pl_in,
  output logic               out_valid,
  output logic [W-1:0]       quo,
  output logic [PW-1:0]      pl_out
);

  logic [W-1:0]  rem_r [1:W];
  logic [W-1:0]  rq_r  [1:W];
  logic [W-1:0]  den_r [1:W];
  logic [PW-1:0] pl_r  [1:W];
  logic [W:1]    vld_r;

  // One quotient bit per stage, restoring form.
  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W-1:0]  s_rem;
    logic [W-1:0]  s_rq;
    logic [W-1:0]  s_den;
    logic [PW-1:0] s_pl;
    logic          s_v;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign s_rem = '0;
      assign s_rq  = num;
      assign s_den = den;
      assign s_pl  = pl_in;
      assign s_v   = ctl.valid;
    end else begin : g_next
      assign s_rem = rem_r[i];
      assign s_rq  = rq_r[i];
      assign s_den = den_r[i];
      assign s_pl  = pl_r[i];
      assign s_v   = vld_r[i];
    end

    assign trial = {s_rem, s_rq[W-1]};
    assign diff  = trial - {1'b0, s_den};
    assign ge    = ~diff[W];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (ctl.adv) begin
        vld_r[i+1] <= s_v;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        rem_r[i+1] <= ge ? diff[W-1:0] : trial[W-1:0];
        rq_r[i+1]  <= {s_rq[W-2:0], ge};
        den_r[i+1] <= s_den;
        pl_r[i+1]  <= s_pl;
      end
    end
  end

  assign out_valid = vld_r[W];
  assign quo       = rq_r[W];
  assign pl_out    = pl_r[W];

  `PSC_ASSERT_NEXT(a_div_hold, clk, rst_n, !ctl.adv, $stable(vld_r))
  `PSC_ASSERT_NEXT(a_div_enter, clk, rst_n, ctl.adv && ctl.valid, vld_r[1])
  `PSC_ASSERT_NEXT(a_div_exit, clk, rst_n, ctl.adv && vld_r[W-1], out_valid)

endmodule
`default_nettype wire

// ===== rtl/core/pressure_sensor_compensation.sv =====
`default_nettype none
`include "pressure_sensor_compensation_macros.svh"
// Barometric compensation core.
// Input channel: in_valid/in_stall carry one raw temperature word and one
// raw pressure word (already shifted by eight minus oversampling) per beat.
// Result channel: out_valid/out_stall carry the temperature in tenths of a
// degree, the pressure in pascals and a divide fault flag per beat.
// Configuration: write cfg_wdata to register cfg_index while cfg_wr_en is
// high; index 0 oversampling, 1..3 the packed calibration words. Write only
// while no beat is in flight.
// Throughput: one beat per cycle while the receiver does not stall. The
// pipeline is two 32-stage bit-per-stage dividers plus twelve arithmetic
// stages around them.
// Reset (synchronous, rst_n low) clears every configuration register and
// empties the pipeline. When the receiver stalls a held result, the whole
// pipeline freezes and in_stall rises; bubbles keep moving while the output
// register is empty.
module pressure_sensor_compensation
  import psc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_raw_temperature,
  input  wire logic [18:0] in_raw_pressure,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_temperature_tenths,
  output logic [31:0]      out_pressure_pa,
  output logic             out_divide_fault
);

  localparam int unsigned PL1_W = 19 + 32 + 2;
  localparam int unsigned PL2_W = 32 + 3;

  logic [1:0]  oss_r;
  logic [63:0] cal_a_r;
  logic [63:0] cal_b_r;
  logic [31:0] cal_c_r;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic        adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oss_r   <= '0;
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_OVERSAMPLING: oss_r   <= cfg_wdata[1:0];
        REG_CAL_A:        cal_a_r <= cfg_wdata;
        REG_CAL_B:        cal_b_r <= cfg_wdata;
        REG_CAL_C:        cal_c_r <= cfg_wdata[31:0];
        default:          oss_r   <= oss_r;
      endcase
    end
  end

  // Unpack coefficients.
  assign ac1 = {{16{cal_a_r[15]}}, cal_a_r[15:0]};
  assign ac2 = {{16{cal_a_r[31]}}, cal_a_r[31:16]};
  assign ac3 = {{16{cal_a_r[47]}}, cal_a_r[47:32]};
  assign ac4 = {16'd0, cal_a_r[63:48]};
  assign ac5 = {16'd0, cal_b_r[15:0]};
  assign ac6 = {16'd0, cal_b_r[31:16]};
  assign b1  = {{16{cal_b_r[47]}}, cal_b_r[47:32]};
  assign b2  = {{16{cal_b_r[63]}}, cal_b_r[63:48]};
  assign mc  = {{16{cal_c_r[15]}}, cal_c_r[15:0]};
  assign md  = {{16{cal_c_r[31]}}, cal_c_r[31:16]};

  // Advance the whole pipe unless a held result is stalled.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: temperature product.
  logic        s1_v_r;
  logic [18:0] s1_up_r;
  logic [31:0] s1_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_up_r <= in_raw_pressure;
      s1_m_r  <= ({16'd0, in_raw_temperature} - ac6) * ac5;
    end
  end

  // Stage 2: x1 and the divisor.
  logic        s2_v_r;
  logic [18:0] s2_up_r;
  logic [31:0] s2_x1_r;
  logic [31:0] s2_den_r;
  logic [31:0] s2_x1_nxt;

  assign s2_x1_nxt = asr32(s1_m_r, 15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_up_r  <= s1_up_r;
      s2_x1_r  <= s2_x1_nxt;
      s2_den_r <= s2_x1_nxt + md;
    end
  end

  // Divider 1: (MC << 11) / den on magnitudes.
  logic [31:0]      d1_num;
  logic [31:0]      d1_num_mag;
  logic [31:0]      d1_den_mag;
  logic             d1_neg;
  logic             d1_zero;
  psc_div_ctl_t     d1_ctl;
  logic             d1_v;
  logic [31:0]      d1_q;
  logic [PL1_W-1:0] d1_pl;

  assign d1_num     = mc << 11;
  assign d1_num_mag = d1_num[31] ? (32'd0 - d1_num) : d1_num;
  assign d1_den_mag = s2_den_r[31] ? (32'd0 - s2_den_r) : s2_den_r;
  assign d1_neg     = d1_num[31] ^ s2_den_r[31];
  assign d1_zero    = (s2_den_r == 32'd0);
  assign d1_ctl     = '{valid: s2_v_r, adv: adv};

  psc_udiv #(.W(DATA_W), .PW(PL1_W)) u_div_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (d1_ctl),
    .num       (d1_num_mag),
    .den       (d1_den_mag),
    .pl_in     ({s2_up_r, s2_x1_r, d1_neg, d1_zero}),
    .out_valid (d1_v),
    .quo       (d1_q),
    .pl_out    (d1_pl)
  );

  // Stage 3: sign fix of x2, zero on fault.
  logic        s3_v_r;
  logic [18:0] s3_up_r;
  logic [31:0] s3_x1_r;
  logic [31:0] s3_x2_r;
  logic        s3_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_up_r <= d1_pl[PL1_W-1 -: 19];
      s3_x1_r <= d1_pl[33:2];
      s3_f_r  <= d1_pl[0];
      s3_x2_r <= d1_pl[0] ? 32'd0 : (d1_pl[1] ? (32'd0 - d1_q) : d1_q);
    end
  end

  // Stage 4: b5, temperature and b6.
  logic        s4_v_r;
  logic [18:0] s4_up_r;
  logic [31:0] s4_temp_r;
  logic [31:0] s4_b6_r;
  logic        s4_f_r;
  logic [31:0] b5;

  assign b5 = s3_x1_r + s3_x2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_up_r   <= s3_up_r;
      s4_temp_r <= asr32(b5 + 32'd8, 4);
      s4_b6_r   <= b5 - B6_OFFSET;
      s4_f_r    <= s3_f_r;
    end
  end

  // Stage 5: products on b6.
  logic        s5_v_r;
  logic [18:0] s5_up_r;
  logic [31:0] s5_temp_r;
  logic        s5_f_r;
  logic [31:0] s5_sqp_r;
  logic [31:0] s5_a2p_r;
  logic [31:0] s5_a3p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_up_r   <= s4_up_r;
      s5_temp_r <= s4_temp_r;
      s5_f_r    <= s4_f_r;
      s5_sqp_r  <= s4_b6_r * s4_b6_r;
      s5_a2p_r  <= ac2 * s4_b6_r;
      s5_a3p_r  <= ac3 * s4_b6_r;
    end
  end

  // Stage 6: coefficient products on the square term, and shifts of the b6 products.
  logic        s6_v_r;
  logic [18:0] s6_up_r;
  logic [31:0] s6_temp_r;
  logic        s6_f_r;
  logic [31:0] s6_b2p_r;
  logic [31:0] s6_b1p_r;
  logic [31:0] s6_x2a_r;
  logic [31:0] s6_x1c_r;
  logic [31:0] sq;

  assign sq = asr32(s5_sqp_r, 12);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_up_r   <= s5_up_r;
      s6_temp_r <= s5_temp_r;
      s6_f_r    <= s5_f_r;
      s6_b2p_r  <= b2 * sq;
      s6_b1p_r  <= b1 * sq;
      s6_x2a_r  <= asr32(s5_a2p_r, 11);
      s6_x1c_r  <= asr32(s5_a3p_r, 13);
    end
  end

  // Stage 7: b3 and the b4 multiplicand.
  logic        s7_v_r;
  logic [18:0] s7_up_r;
  logic [31:0] s7_temp_r;
  logic        s7_f_r;
  logic [31:0] s7_b3_r;
  logic [31:0] s7_t_r;
  logic [31:0] b3_sum;
  logic [31:0] b3_val;

  assign b3_sum = ((ac1 << 2) + asr32(s6_b2p_r, 11) + s6_x2a_r);
  assign b3_val = (b3_sum << oss_r) + 32'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (adv) begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_up_r   <= s6_up_r;
      s7_temp_r <= s6_temp_r;
      s7_f_r    <= s6_f_r;
      // Divide by four, truncating toward zero.
      s7_b3_r   <= b3_val[31] ? asr32(b3_val + 32'd3, 2) : asr32(b3_val, 2);
      s7_t_r    <= asr32(s6_x1c_r + asr32(s6_b1p_r, 16) + 32'd2, 2) + B4_BIAS;
    end
  end

  // Stage 8: b4 product and b7.
  logic        s8_v_r;
  logic [31:0] s8_temp_r;
  logic        s8_f_r;
  logic [31:0] s8_p4_r;
  logic [31:0] s8_b7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (adv) begin
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_temp_r <= s7_temp_r;
      s8_f_r    <= s7_f_r;
      s8_p4_r   <= ac4 * s7_t_r;
      s8_b7_r   <= ({13'd0, s7_up_r} - s7_b3_r) * (B7_SCALE >> oss_r);
    end
  end

  // Divider 2: b7 over b4, unsigned; b7 is doubled first unless its top bit is set, then the quotient is doubled.
  logic [31:0]      b4;
  logic             d2_big;
  logic             d2_zero;
  psc_div_ctl_t     d2_ctl;
  logic             d2_v;
  logic [31:0]      d2_q;
  logic [PL2_W-1:0] d2_pl;

  assign b4      = s8_p4_r >> 15;
  assign d2_big  = s8_b7_r[31];
  assign d2_zero = (b4 == 32'd0);
  assign d2_ctl  = '{valid: s8_v_r, adv: adv};

  psc_udiv #(.W(DATA_W), .PW(PL2_W)) u_div_pres (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (d2_ctl),
    .num       (d2_big ? s8_b7_r : (s8_b7_r << 1)),
    .den       (b4),
    .pl_in     ({s8_temp_r, s8_f_r | d2_zero, d2_zero, d2_big}),
    .out_valid (d2_v),
    .quo       (d2_q),
    .pl_out    (d2_pl)
  );

  // Stage 10: raw pressure quotient.
  logic        s10_v_r;
  logic [31:0] s10_temp_r;
  logic        s10_f_r;
  logic [31:0] s10_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_v_r <= 1'b0;
    end else if (adv) begin
      s10_v_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_temp_r <= d2_pl[PL2_W-1 -: 32];
      s10_f_r    <= d2_pl[2];
      s10_p_r    <= d2_pl[1] ? 32'd0 : (d2_pl[0] ? (d2_q << 1) : d2_q);
    end
  end

  // Stage 11: correction products.
  logic        s11_v_r;
  logic [31:0] s11_temp_r;
  logic        s11_f_r;
  logic [31:0] s11_p_r;
  logic [31:0] s11_pp_r;
  logic [31:0] s11_q7_r;
  logic [31:0] ph;

  assign ph = asr32(s10_p_r, 8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s11_v_r <= 1'b0;
    end else if (adv) begin
      s11_v_r <= s10_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_temp_r <= s10_temp_r;
      s11_f_r    <= s10_f_r;
      s11_p_r    <= s10_p_r;
      s11_pp_r   <= ph * ph;
      s11_q7_r   <= P_LIN_COEF * s10_p_r;
    end
  end

  // Stage 12: square term coefficient.
  logic        s12_v_r;
  logic [31:0] s12_temp_r;
  logic        s12_f_r;
  logic [31:0] s12_p_r;
  logic [31:0] s12_pm_r;
  logic [31:0] s12_q7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s12_v_r <= 1'b0;
    end else if (adv) begin
      s12_v_r <= s11_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_temp_r <= s11_temp_r;
      s12_f_r    <= s11_f_r;
      s12_p_r    <= s11_p_r;
      s12_pm_r   <= s11_pp_r * P_SQ_COEF;
      s12_q7_r   <= s11_q7_r;
    end
  end

  // Output register: final pressure correction.
  logic        out_v_r;
  logic [31:0] out_temp_r;
  logic [31:0] out_p_r;
  logic        out_f_r;
  logic [31:0] corr;

  assign corr = asr32(asr32(s12_pm_r, 16) + asr32(s12_q7_r, 16) + P_OFFSET, 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s12_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_temp_r <= s12_temp_r;
      out_p_r    <= s12_p_r + corr;
      out_f_r    <= s12_f_r;
    end
  end

  assign out_valid              = out_v_r;
  assign out_temperature_tenths = out_temp_r;
  assign out_pressure_pa        = out_p_r;
  assign out_divide_fault       = out_f_r;

  `PSC_ASSERT_NEXT(a_keep_result, clk, rst_n, out_valid && out_stall, out_valid)
  `PSC_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
  `PSC_ASSERT_NEXT(a_enter, clk, rst_n, in_valid && !in_stall, s1_v_r)

endmodule
`default_nettype wire
